// File: hdl/lvm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Formats, widths, shared types and rounding and saturation helpers of the look-at block.
// ----------------------------------------------------------------------------
package lvm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 24;
	localparam int AXIS_W    = 18;
	localparam int OFS_W     = 25;

	localparam int DIF_W  = IN_W + 1;
	localparam int PROD_W = IN_W + AXIS_W;
	localparam int CRS_W  = PROD_W + 1;
	localparam int DOT_W  = PROD_W + 2;
	localparam int POS_W  = $clog2(CRS_W);
	localparam int NM_W   = 25;
	localparam int SUM_W  = 2 * NM_W + 2;
	localparam int SQ_W   = NM_W + 1;
	localparam int DIV_W  = SQ_W + FRAC_BITS + 1;
	localparam int Q_W    = FRAC_BITS + 1;
	localparam int CMP_W  = (Q_W > AXIS_W) ? Q_W : AXIS_W;
	localparam int AXIS_MAX = (1 << (AXIS_W - 1)) - 1;

	localparam logic signed [DOT_W-1:0] AX_HI = DOT_W'((64'sd1 <<< (AXIS_W - 1)) - 64'sd1);
	localparam logic signed [DOT_W-1:0] AX_LO = DOT_W'(-(64'sd1 <<< (AXIS_W - 1)));
	localparam logic signed [DOT_W-1:0] OF_HI = DOT_W'((64'sd1 <<< (OFS_W - 1)) - 64'sd1);
	localparam logic signed [DOT_W-1:0] OF_LO = DOT_W'(-(64'sd1 <<< (OFS_W - 1)));

	typedef logic signed [IN_W-1:0]   in_t;
	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic signed [OFS_W-1:0]  ofs_t;
	typedef logic signed [CRS_W-1:0]  crs_t;

	typedef struct packed {
		logic [2:0][IN_W-1:0]   eye;
		logic [2:0][IN_W-1:0]   aux;
		logic [2:0][AXIS_W-1:0] axis;
	} tag_t;

	// divide by 2^FRAC_BITS, round half away from zero
	function automatic logic signed [DOT_W-1:0] rnd_frac(input logic signed [DOT_W-1:0] x);
		logic [DOT_W-1:0] m;
		logic [DOT_W-1:0] r;
		m = x[DOT_W-1] ? DOT_W'(-x) : DOT_W'(x);
		r = (m + (DOT_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return x[DOT_W-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic axis_t sat_axis(input logic signed [DOT_W-1:0] x);
		if (x > AX_HI) return AXIS_W'(AX_HI);
		if (x < AX_LO) return AXIS_W'(AX_LO);
		return AXIS_W'(x);
	endfunction

	function automatic ofs_t sat_ofs(input logic signed [DOT_W-1:0] x);
		if (x > OF_HI) return OFS_W'(OF_HI);
		if (x < OF_LO) return OFS_W'(OF_LO);
		return OFS_W'(x);
	endfunction

endpackage

// File: hdl/lvm_norm.sv
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a 3-vector to unit length: leading-one search, range shift, sum of
// squares, bit-per-stage square root and bit-per-stage division.
// ----------------------------------------------------------------------------
module lvm_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  lvm_pkg::crs_t  vec [3],
	input  lvm_pkg::tag_t  in_tag,
	output logic           out_vld,
	output lvm_pkg::axis_t axis [3],
	output lvm_pkg::tag_t  out_tag
);
	localparam int MW = lvm_pkg::CRS_W;
	localparam int NW = lvm_pkg::NM_W;
	localparam int SW = lvm_pkg::SUM_W;
	localparam int RW = lvm_pkg::SQ_W;
	localparam int DW = lvm_pkg::DIV_W;
	localparam int QW = lvm_pkg::Q_W;
	localparam int PW = lvm_pkg::POS_W;
	localparam int CW = lvm_pkg::CMP_W;
	localparam int AW = lvm_pkg::AXIS_W;
	localparam int F  = lvm_pkg::FRAC_BITS;

	typedef struct packed {
		logic                 zero;
		logic [2:0]           neg;
		logic [2:0][NW-1:0]   nm;
		lvm_pkg::tag_t        tag;
	} sd_t;

	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [MW-1:0] mag_c [3];
	logic [MW-1:0] mag_s1 [3];
	logic [MW-1:0] mag_s2 [3];
	logic [MW-1:0] or_s1;
	logic [2:0]    neg_s1, neg_s2;
	lvm_pkg::tag_t tag_s1, tag_s2;
	logic [PW-1:0] pos_c, pos_s2;
	logic          zero_s2;
	logic [NW-1:0] nm_c [3];
	sd_t           sd_s3, sd_s4, sd_s5;
	logic [2*NW-1:0] sq_s4 [3];
	logic [SW-1:0] sum_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec[i][MW-1] ? MW'(-vec[i]) : MW'(vec[i]);
		end
	end

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < MW; b++) begin
			if (or_s1[b]) pos_c = PW'(b);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= PW'(NW - 1)) begin
				nm_c[i] = NW'(mag_s2[i] >> (pos_s2 - PW'(NW - 1)));
			end else begin
				nm_c[i] = NW'(mag_s2[i] << (PW'(NW - 1) - pos_s2));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_c[i];
			neg_s1[i] <= vec[i][MW-1];
			mag_s2[i] <= mag_s1[i];
			sd_s3.nm[i] <= nm_c[i];
			sq_s4[i] <= sd_s3.nm[i] * sd_s3.nm[i];
		end
		or_s1     <= mag_c[0] | mag_c[1] | mag_c[2];
		tag_s1    <= in_tag;
		pos_s2    <= pos_c;
		zero_s2   <= (or_s1 == '0);
		neg_s2    <= neg_s1;
		tag_s2    <= tag_s1;
		sd_s3.zero <= zero_s2;
		sd_s3.neg  <= neg_s2;
		sd_s3.tag  <= tag_s2;
		sd_s4     <= sd_s3;
		sd_s5     <= sd_s4;
		sum_s5    <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
	end

	logic [SW-1:0] rt_rem_s  [RW];
	logic [RW-1:0] rt_root_s [RW];
	sd_t           rt_sd_s   [RW];
	logic          rt_vld_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		logic [SW-1:0] rem_i;
		logic [RW-1:0] root_i;
		sd_t           sd_i;
		logic          vld_i;
		logic [SW-1:0] cand;
		if (k == 0) begin : g_first
			assign rem_i  = sum_s5;
			assign root_i = '0;
			assign sd_i   = sd_s5;
			assign vld_i  = vld_s5;
		end else begin : g_next
			assign rem_i  = rt_rem_s[k-1];
			assign root_i = rt_root_s[k-1];
			assign sd_i   = rt_sd_s[k-1];
			assign vld_i  = rt_vld_s[k-1];
		end
		assign cand = (SW'(root_i) << (B + 1)) + (SW'(1) << (2 * B));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else begin
				rt_vld_s[k] <= vld_i;
			end
		end
		always_ff @(posedge clk) begin
			if (rem_i >= cand) begin
				rt_rem_s[k]  <= rem_i - cand;
				rt_root_s[k] <= root_i | (RW'(1) << B);
			end else begin
				rt_rem_s[k]  <= rem_i;
				rt_root_s[k] <= root_i;
			end
			rt_sd_s[k] <= sd_i;
		end
	end

	logic [DW-1:0] dv_init [3];
	logic [DW-1:0] dv_rem_s [QW][3];
	logic [QW-1:0] dv_q_s   [QW][3];
	logic [RW-1:0] dv_len_s [QW];
	sd_t           dv_sd_s  [QW];
	logic          dv_vld_s [QW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_init[i] = (DW'(rt_sd_s[RW-1].nm[i]) << F) + DW'(rt_root_s[RW-1] >> 1);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [DW-1:0] rem_i [3];
		logic [QW-1:0] q_i   [3];
		logic [RW-1:0] len_i;
		sd_t           sd_i;
		logic          vld_i;
		logic [DW-1:0] dsr;
		if (k == 0) begin : g_first
			assign rem_i = dv_init;
			assign q_i   = '{default: '0};
			assign len_i = rt_root_s[RW-1];
			assign sd_i  = rt_sd_s[RW-1];
			assign vld_i = rt_vld_s[RW-1];
		end else begin : g_next
			assign rem_i = dv_rem_s[k-1];
			assign q_i   = dv_q_s[k-1];
			assign len_i = dv_len_s[k-1];
			assign sd_i  = dv_sd_s[k-1];
			assign vld_i = dv_vld_s[k-1];
		end
		assign dsr = DW'(len_i) << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else begin
				dv_vld_s[k] <= vld_i;
			end
		end
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_i[i] >= dsr) begin
					dv_rem_s[k][i] <= rem_i[i] - dsr;
					dv_q_s[k][i]   <= q_i[i] | (QW'(1) << B);
				end else begin
					dv_rem_s[k][i] <= rem_i[i];
					dv_q_s[k][i]   <= q_i[i];
				end
			end
			dv_len_s[k] <= len_i;
			dv_sd_s[k]  <= sd_i;
		end
	end

	lvm_pkg::axis_t ax_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (CW'(dv_q_s[QW-1][i]) > CW'(lvm_pkg::AXIS_MAX)) begin
				ax_c[i] = AW'(lvm_pkg::AXIS_MAX);
			end else begin
				ax_c[i] = AW'(dv_q_s[QW-1][i]);
			end
			if (dv_sd_s[QW-1].zero) begin
				ax_c[i] = '0;
			end else if (dv_sd_s[QW-1].neg[i]) begin
				ax_c[i] = -ax_c[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= dv_vld_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		axis    <= ax_c;
		out_tag <= dv_sd_s[QW-1].tag;
	end

endmodule

// File: hdl/lvm_cross.sv
// ----------------------------------------------------------------------------
// Cross product
// Two-stage signed cross product a x b: products, then differences.
// ----------------------------------------------------------------------------
module lvm_cross (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  lvm_pkg::in_t   a [3],
	input  lvm_pkg::axis_t b [3],
	input  lvm_pkg::tag_t  in_tag,
	output logic           out_vld,
	output lvm_pkg::crs_t  o [3],
	output lvm_pkg::tag_t  out_tag
);
	localparam int PW = lvm_pkg::PROD_W;
	localparam int CW = lvm_pkg::CRS_W;

	logic                 vld_s1;
	logic signed [PW-1:0] p_s1 [6];
	lvm_pkg::tag_t        tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= a[1] * b[2];
		p_s1[1] <= a[2] * b[1];
		p_s1[2] <= a[2] * b[0];
		p_s1[3] <= a[0] * b[2];
		p_s1[4] <= a[0] * b[1];
		p_s1[5] <= a[1] * b[0];
		tag_s1  <= in_tag;
		o[0]    <= CW'(p_s1[0]) - CW'(p_s1[1]);
		o[1]    <= CW'(p_s1[2]) - CW'(p_s1[3]);
		o[2]    <= CW'(p_s1[4]) - CW'(p_s1[5]);
		out_tag <= tag_s1;
	end

endmodule

// File: hdl/lvm_dot.sv
// ----------------------------------------------------------------------------
// Offset unit
// Negated dot product of an axis with the eye point, rounded and saturated.
// ----------------------------------------------------------------------------
module lvm_dot (
	input  logic           clk,
	input  lvm_pkg::axis_t axis [3],
	input  lvm_pkg::in_t   eye [3],
	output lvm_pkg::ofs_t  ofs
);
	localparam int PW = lvm_pkg::PROD_W;
	localparam int DW = lvm_pkg::DOT_W;

	logic signed [PW-1:0] p_s1 [3];
	logic signed [DW-1:0] sum_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s1[i] <= axis[i] * eye[i];
		end
		sum_s2 <= DW'(p_s1[0]) + DW'(p_s1[1]) + DW'(p_s1[2]);
		ofs    <= lvm_pkg::sat_ofs(lvm_pkg::rnd_frac(-sum_s2));
	end

endmodule

// File: hdl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the twelve varying elements of a left-handed look-at view matrix
// from a camera's eye, target and up vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Drive eye, target and up (signed, FRAC_BITS fraction bits) and raise
//   start for one cycle per item. busy stays low: the block is a pipeline
//   and takes an item in every cycle.
//   Each item gives one result: done is high for exactly one cycle while
//   the three axes and three offsets are on the outputs.
//   The path from input to result is an input register, two normalizers of
//   FRAC_BITS + 33 stages each (square root one bit per stage, divider one
//   quotient bit per stage), two cross product units of 2 stages, a
//   rounding stage and a 3-stage offset unit.
//   Throughput is one item per cycle.
//   Reset clears all valid bits; no result appears until an item enters.
//   The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lvm_pkg::in_t   eye_x,
	input  lvm_pkg::in_t   eye_y,
	input  lvm_pkg::in_t   eye_z,
	input  lvm_pkg::in_t   target_x,
	input  lvm_pkg::in_t   target_y,
	input  lvm_pkg::in_t   target_z,
	input  lvm_pkg::in_t   up_x,
	input  lvm_pkg::in_t   up_y,
	input  lvm_pkg::in_t   up_z,
	output logic           done,
	output lvm_pkg::axis_t side_axis_x,
	output lvm_pkg::axis_t side_axis_y,
	output lvm_pkg::axis_t side_axis_z,
	output lvm_pkg::ofs_t  side_offset,
	output lvm_pkg::axis_t camera_up_x,
	output lvm_pkg::axis_t camera_up_y,
	output lvm_pkg::axis_t camera_up_z,
	output lvm_pkg::ofs_t  up_offset,
	output lvm_pkg::axis_t gaze_axis_x,
	output lvm_pkg::axis_t gaze_axis_y,
	output lvm_pkg::axis_t gaze_axis_z,
	output lvm_pkg::ofs_t  gaze_offset
);
	localparam int DFW = lvm_pkg::DIF_W;
	localparam int CW  = lvm_pkg::CRS_W;
	localparam int IW  = lvm_pkg::IN_W;
	localparam int AW  = lvm_pkg::AXIS_W;
	localparam int DW  = lvm_pkg::DOT_W;

	logic                  vld_s1;
	logic signed [DFW-1:0] d_s1 [3];
	lvm_pkg::tag_t         tag_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		d_s1[0]         <= DFW'(target_x) - DFW'(eye_x);
		d_s1[1]         <= DFW'(target_y) - DFW'(eye_y);
		d_s1[2]         <= DFW'(target_z) - DFW'(eye_z);
		tag_s1.eye[0]   <= eye_x;
		tag_s1.eye[1]   <= eye_y;
		tag_s1.eye[2]   <= eye_z;
		tag_s1.aux[0]   <= up_x;
		tag_s1.aux[1]   <= up_y;
		tag_s1.aux[2]   <= up_z;
		tag_s1.axis     <= '0;
	end

	lvm_pkg::crs_t  dvec [3];
	logic           n1_vld;
	lvm_pkg::axis_t gaze [3];
	lvm_pkg::tag_t  n1_tag;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dvec[i] = CW'(d_s1[i]);
		end
	end

	lvm_norm u_norm_gaze (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.vec     (dvec),
		.in_tag  (tag_s1),
		.out_vld (n1_vld),
		.axis    (gaze),
		.out_tag (n1_tag)
	);

	lvm_pkg::in_t   c1_a [3];
	lvm_pkg::tag_t  c1_tag_in;
	logic           c1_vld;
	lvm_pkg::crs_t  sc [3];
	lvm_pkg::tag_t  c1_tag;

	always_comb begin
		c1_tag_in.eye  = n1_tag.eye;
		c1_tag_in.axis = '0;
		for (int i = 0; i < 3; i++) begin
			c1_a[i]          = $signed(n1_tag.aux[i]);
			c1_tag_in.aux[i] = IW'(gaze[i]);
		end
	end

	lvm_cross u_cross_side (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (n1_vld),
		.a       (c1_a),
		.b       (gaze),
		.in_tag  (c1_tag_in),
		.out_vld (c1_vld),
		.o       (sc),
		.out_tag (c1_tag)
	);

	logic           n2_vld;
	lvm_pkg::axis_t side [3];
	lvm_pkg::tag_t  n2_tag;

	lvm_norm u_norm_side (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (c1_vld),
		.vec     (sc),
		.in_tag  (c1_tag),
		.out_vld (n2_vld),
		.axis    (side),
		.out_tag (n2_tag)
	);

	lvm_pkg::in_t   c2_a [3];
	lvm_pkg::tag_t  c2_tag_in;
	logic           c2_vld;
	lvm_pkg::crs_t  cu_raw [3];
	lvm_pkg::tag_t  c2_tag;

	always_comb begin
		c2_tag_in.eye = n2_tag.eye;
		c2_tag_in.aux = n2_tag.aux;
		for (int i = 0; i < 3; i++) begin
			c2_a[i]           = $signed(n2_tag.aux[i]);
			c2_tag_in.axis[i] = side[i];
		end
	end

	lvm_cross u_cross_up (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (n2_vld),
		.a       (c2_a),
		.b       (side),
		.in_tag  (c2_tag_in),
		.out_vld (c2_vld),
		.o       (cu_raw),
		.out_tag (c2_tag)
	);

	logic           vld_s2, vld_s3, vld_s4, vld_s5;
	lvm_pkg::axis_t cu_s2 [3], sd_s2 [3], gz_s2 [3];
	lvm_pkg::in_t   eye_s2 [3];
	lvm_pkg::axis_t cu_s3 [3], sd_s3 [3], gz_s3 [3];
	lvm_pkg::axis_t cu_s4 [3], sd_s4 [3], gz_s4 [3];
	lvm_pkg::axis_t cu_s5 [3], sd_s5 [3], gz_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= c2_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cu_s2[i]  <= lvm_pkg::sat_axis(lvm_pkg::rnd_frac(DW'(cu_raw[i])));
			sd_s2[i]  <= $signed(c2_tag.axis[i]);
			gz_s2[i]  <= AW'(c2_tag.aux[i]);
			eye_s2[i] <= $signed(c2_tag.eye[i]);
			cu_s3[i]  <= cu_s2[i];
			sd_s3[i]  <= sd_s2[i];
			gz_s3[i]  <= gz_s2[i];
			cu_s4[i]  <= cu_s3[i];
			sd_s4[i]  <= sd_s3[i];
			gz_s4[i]  <= gz_s3[i];
			cu_s5[i]  <= cu_s4[i];
			sd_s5[i]  <= sd_s4[i];
			gz_s5[i]  <= gz_s4[i];
		end
	end

	lvm_dot u_dot_side (
		.clk  (clk),
		.axis (sd_s2),
		.eye  (eye_s2),
		.ofs  (side_offset)
	);

	lvm_dot u_dot_up (
		.clk  (clk),
		.axis (cu_s2),
		.eye  (eye_s2),
		.ofs  (up_offset)
	);

	lvm_dot u_dot_gaze (
		.clk  (clk),
		.axis (gz_s2),
		.eye  (eye_s2),
		.ofs  (gaze_offset)
	);

	assign done        = vld_s5;
	assign side_axis_x = sd_s5[0];
	assign side_axis_y = sd_s5[1];
	assign side_axis_z = sd_s5[2];
	assign camera_up_x = cu_s5[0];
	assign camera_up_y = cu_s5[1];
	assign camera_up_z = cu_s5[2];
	assign gaze_axis_x = gz_s5[0];
	assign gaze_axis_y = gz_s5[1];
	assign gaze_axis_z = gz_s5[2];

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Sends camera items (eye, target, up) to the look-at block, predicts the
// twelve matrix elements of each in fixed point and compares every result,
// field by field, with the oldest prediction. Directed corner cases come
// first, then random cameras under three sender idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lvm_pkg::*;

	localparam int END_WAIT = 150;

	typedef struct {
		axis_t side_x, side_y, side_z;
		ofs_t  side_ofs;
		axis_t cup_x, cup_y, cup_z;
		ofs_t  up_ofs;
		axis_t gaze_x, gaze_y, gaze_z;
		ofs_t  gaze_ofs;
	} matrix_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy, done;
	in_t   eye_x = '0, eye_y = '0, eye_z = '0;
	in_t   target_x = '0, target_y = '0, target_z = '0;
	in_t   up_x = '0, up_y = '0, up_z = '0;
	axis_t side_axis_x, side_axis_y, side_axis_z;
	axis_t camera_up_x, camera_up_y, camera_up_z;
	axis_t gaze_axis_x, gaze_axis_y, gaze_axis_z;
	ofs_t  side_offset, up_offset, gaze_offset;

	matrix_t pending_matrices[$];
	int      fail_count = 0;
	int      idle_pct = 0;

	look_at_view_matrix uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void unit_vec(input longint v[3], output longint o[3]);
		longint unsigned m[3], mx, len, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			o = '{0, 0, 0};
			return;
		end
		while (mx >= (64'd1 << 25)) begin
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 24)) begin
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
			mx <<= 1;
		end
		len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
			if (q > AXIS_MAX)
				q = AXIS_MAX;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic longint round_frac(input longint x);
		longint m;
		m = x < 0 ? -x : x;
		m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return x < 0 ? -m : m;
	endfunction

	function automatic longint clamp(input longint x, input int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
	endfunction

	function automatic longint neg_dot(input longint a[3], input longint e[3]);
		return clamp(round_frac(-(a[0] * e[0] + a[1] * e[1] + a[2] * e[2])), OFS_W);
	endfunction

	function automatic matrix_t view_matrix(input in_t e[3], input in_t t[3], input in_t u[3]);
		longint eye[3], d[3], up[3], gz[3], sc[3], sd[3], tc[3], cu[3];
		matrix_t r;
		for (int i = 0; i < 3; i++) begin
			eye[i] = e[i];
			up[i] = u[i];
			d[i] = longint'(t[i]) - longint'(e[i]);
		end
		unit_vec(d, gz);
		cross3(up, gz, sc);
		unit_vec(sc, sd);
		cross3(gz, sd, tc);
		for (int i = 0; i < 3; i++)
			cu[i] = clamp(round_frac(tc[i]), AXIS_W);
		r.side_x = axis_t'(sd[0]); r.side_y = axis_t'(sd[1]); r.side_z = axis_t'(sd[2]);
		r.cup_x = axis_t'(cu[0]); r.cup_y = axis_t'(cu[1]); r.cup_z = axis_t'(cu[2]);
		r.gaze_x = axis_t'(gz[0]); r.gaze_y = axis_t'(gz[1]); r.gaze_z = axis_t'(gz[2]);
		r.side_ofs = ofs_t'(neg_dot(sd, eye));
		r.up_ofs = ofs_t'(neg_dot(cu, eye));
		r.gaze_ofs = ofs_t'(neg_dot(gz, eye));
		return r;
	endfunction

	// send one item, starting at a falling edge; returns after acceptance and any idle cycles
	task automatic send_camera(input in_t e[3], input in_t t[3], input in_t u[3]);
		logic taken;
		@(negedge clk);
		eye_x <= e[0]; eye_y <= e[1]; eye_z <= e[2];
		target_x <= t[0]; target_y <= t[1]; target_z <= t[2];
		up_x <= u[0]; up_y <= u[1]; up_z <= u[2];
		start <= 1'b1;
		forever begin
			taken = !busy;
			@(posedge clk);
			if (taken)
				break;
			@(negedge clk);
		end
		pending_matrices.push_back(view_matrix(e, t, u));
		// idle each following cycle with a probability of idle_pct percent
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		matrix_t x;
		if (arst_n && done) begin
			if (pending_matrices.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual done", $time);
				fail_count++;
			end else begin
				x = pending_matrices.pop_front();
				check_field("side_axis_x", x.side_x, side_axis_x);
				check_field("side_axis_y", x.side_y, side_axis_y);
				check_field("side_axis_z", x.side_z, side_axis_z);
				check_field("side_offset", x.side_ofs, side_offset);
				check_field("camera_up_x", x.cup_x, camera_up_x);
				check_field("camera_up_y", x.cup_y, camera_up_y);
				check_field("camera_up_z", x.cup_z, camera_up_z);
				check_field("up_offset", x.up_ofs, up_offset);
				check_field("gaze_axis_x", x.gaze_x, gaze_axis_x);
				check_field("gaze_axis_y", x.gaze_y, gaze_axis_y);
				check_field("gaze_axis_z", x.gaze_z, gaze_axis_z);
				check_field("gaze_offset", x.gaze_ofs, gaze_offset);
			end
		end
	end

	function automatic in_t pick_coord();
		case ($urandom_range(7))
			0: return in_t'(-(1 << (IN_W - 1)));
			1: return in_t'((1 << (IN_W - 1)) - 1);
			2: return in_t'($signed(10'($urandom)));
			3: return '0;
			default: return in_t'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		in_t mx, mn, one;
		mx = in_t'((1 << (IN_W - 1)) - 1);
		mn = in_t'(-(1 << (IN_W - 1)));
		one = in_t'(1 << FRAC_BITS);
		send_camera('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
		send_camera('{0, 0, 0}, '{0, 0, one}, '{0, one, 0});
		send_camera('{one, 2, 3}, '{one, 2, 3}, '{0, one, 0});
		send_camera('{0, 0, 0}, '{0, one, 0}, '{0, one, 0});
		send_camera('{5, 5, 5}, '{5, 5 + one, 5}, '{0, -3, 0});
		send_camera('{0, 0, 0}, '{one, 0, 0}, '{0, 0, 0});
		send_camera('{mn, mn, mn}, '{mx, mx, mx}, '{mx, mn, mx});
		send_camera('{mx, mx, mx}, '{mn, mn, mn}, '{mn, mx, mn});
		send_camera('{mx, mn, mx}, '{mn, mx, mn}, '{0, mx, 0});
		send_camera('{mn, mx, 0}, '{mx, mn, 0}, '{0, 0, mn});
		send_camera('{mx, mx, mx}, '{0, 0, 0}, '{one, 0, 0});
		send_camera('{mn, mn, mn}, '{0, 0, 0}, '{0, 0, 1});
		send_camera('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0});
		send_camera('{0, 0, 0}, '{-1, -1, -1}, '{1, 0, 0});
		send_camera('{one, one, one}, '{one, one, 0}, '{0, one, 0});
		send_camera('{mx, 0, 0}, '{0, mx, 0}, '{0, 0, mx});
		send_camera('{-one, 0, 0}, '{0, 0, 0}, '{-7, one, 3});
	endtask

	task automatic test_random(input int n_items, input int pct);
		in_t e[3], t[3], u[3];
		int k;
		idle_pct = pct;
		repeat (n_items) begin
			for (int i = 0; i < 3; i++) begin
				e[i] = pick_coord();
				t[i] = pick_coord();
				u[i] = pick_coord();
			end
			case ($urandom_range(9))
				0: t = e;
				1: begin
					k = $urandom_range(1, 3);
					for (int i = 0; i < 3; i++) begin
						t[i] = in_t'($signed(12'($urandom)));
						e[i] = in_t'($signed(12'($urandom)));
						u[i] = in_t'(k * (t[i] - e[i]));
					end
				end
				2: u = '{0, 0, 0};
				default: ;
			endcase
			send_camera(e, t, u);
		end
		@(negedge clk);
		start <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_pct = 18;
		test_directed();
		test_random(400, 18);
		test_random(400, 77);
		test_random(430, 0);
		while (pending_matrices.size() != 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
